// ===== rtl/ecb_pkg.sv =====
// ============================================================================
// ecb_pkg
// shared types, constants and the cordic arctangent table for the camera basis
// ============================================================================
`default_nettype none

package ecb_pkg;

    // one input transaction
    typedef struct packed {
        logic [15:0] yaw_angle;
        logic [15:0] pitch_angle;
    } t_in;

    // one result transaction
    typedef struct packed {
        logic signed [15:0] forward_x;
        logic signed [15:0] forward_y;
        logic signed [15:0] forward_z;
        logic signed [15:0] right_x;
        logic signed [15:0] right_y;
        logic signed [15:0] right_z;
        logic signed [15:0] up_x;
        logic signed [15:0] up_y;
        logic signed [15:0] up_z;
        logic               degenerate;
    } t_out;

    // internal vector component, q30 for unit vectors and q28 for cross products
    typedef logic signed [31:0] t_q;

    typedef struct packed {
        t_q x;
        t_q y;
        t_q z;
    } t_vec3;

    localparam int VEC_W = $bits(t_vec3);

    // configuration register indexes
    localparam logic [1:0] CFG_UP_X = 2'd0;
    localparam logic [1:0] CFG_UP_Y = 2'd1;
    localparam logic [1:0] CFG_UP_Z = 2'd2;

    // cordic datapath
    localparam int CORDIC_STEPS = 30;
    localparam int CORDIC_W     = 34;

    typedef logic signed [CORDIC_W-1:0] t_cw;

    localparam t_cw CORDIC_GAIN = 34'sd652032874;

    // arctangent of 2^-i in 2^32-per-turn units
    function automatic t_cw cordic_atan(input logic [4:0] idx);
        logic [31:0] a;
        case (idx)
            5'd0:  a = 32'h20000000;
            5'd1:  a = 32'h12E4051E;
            5'd2:  a = 32'h09FB385B;
            5'd3:  a = 32'h051111D4;
            5'd4:  a = 32'h028B0D43;
            5'd5:  a = 32'h0145D7E1;
            5'd6:  a = 32'h00A2F61E;
            5'd7:  a = 32'h00517C55;
            5'd8:  a = 32'h0028BE53;
            5'd9:  a = 32'h00145F2F;
            5'd10: a = 32'h000A2F98;
            5'd11: a = 32'h000517CC;
            5'd12: a = 32'h00028BE6;
            5'd13: a = 32'h000145F3;
            5'd14: a = 32'h0000A2FA;
            5'd15: a = 32'h0000517D;
            5'd16: a = 32'h000028BE;
            5'd17: a = 32'h0000145F;
            5'd18: a = 32'h00000A30;
            5'd19: a = 32'h00000518;
            5'd20: a = 32'h0000028C;
            5'd21: a = 32'h00000146;
            5'd22: a = 32'h000000A3;
            5'd23: a = 32'h00000051;
            5'd24: a = 32'h00000029;
            5'd25: a = 32'h00000014;
            5'd26: a = 32'h0000000A;
            5'd27: a = 32'h00000005;
            5'd28: a = 32'h00000003;
            5'd29: a = 32'h00000001;
            default: a = 32'h00000000;
        endcase
        return t_cw'({2'b00, a});
    endfunction

endpackage

`default_nettype wire

// ===== rtl/ecb_sincos.sv =====
// ============================================================================
// ecb_sincos
// pipelined rotation-mode cordic giving q30 cosine and sine of a 32-bit angle
// ============================================================================
`default_nettype none

module ecb_sincos (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  logic [31:0]   i_angle,
    output logic          o_valid,
    output ecb_pkg::t_cw  o_cos,
    output ecb_pkg::t_cw  o_sin
);
    import ecb_pkg::*;

    localparam int N = CORDIC_STEPS;

    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;

    logic [N:0]  r_v;
    t_cw         r_x [0:N];
    t_cw         r_y [0:N];
    t_cw         r_z [0:N];
    logic [1:0]  r_q [0:N];
    logic        r_ov;
    t_cw         r_cos;
    t_cw         r_sin;

    logic [1:0]  n_q;
    logic [31:0] n_ru;

    // quarter-turn reduction into -45..45 degrees
    always_comb begin
        n_q  = 2'((i_angle + 32'h2000_0000) >> 30);
        n_ru = i_angle - {n_q, 30'd0};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v  <= '0;
            r_ov <= 1'b0;
        end else if (i_en) begin
            r_v  <= {r_v[N-1:0], i_valid};
            r_ov <= r_v[N];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q[0] <= n_q;
            r_z[0] <= t_cw'($signed(n_ru));
            r_x[0] <= CORDIC_GAIN;
            r_y[0] <= '0;
            for (int i = 0; i < N; i++) begin
                r_q[i+1] <= r_q[i];
                if (!r_z[i][CORDIC_W-1]) begin
                    r_x[i+1] <= r_x[i] - (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] + (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] - cordic_atan(5'(i));
                end else begin
                    r_x[i+1] <= r_x[i] + (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] - (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] + cordic_atan(5'(i));
                end
            end
            // undo the quadrant reduction
            case (r_q[N])
                QUAD_0: begin
                    r_cos <= r_x[N];
                    r_sin <= r_y[N];
                end
                QUAD_1: begin
                    r_cos <= -r_y[N];
                    r_sin <= r_x[N];
                end
                QUAD_2: begin
                    r_cos <= -r_x[N];
                    r_sin <= -r_y[N];
                end
                default: begin
                    r_cos <= r_y[N];
                    r_sin <= -r_x[N];
                end
            endcase
        end
    end

    assign o_valid = r_ov;
    assign o_cos   = r_cos;
    assign o_sin   = r_sin;

endmodule

`default_nettype wire

// ===== rtl/ecb_cross.sv =====
// ============================================================================
// ecb_cross
// pipelined cross product of two q30 vectors, rounded to q28
// ============================================================================
`default_nettype none

module ecb_cross #(
    parameter int SIDE_W = 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  ecb_pkg::t_vec3       i_a,
    input  ecb_pkg::t_vec3       i_b,
    input  logic [SIDE_W-1:0]    i_side,
    output logic                 o_valid,
    output ecb_pkg::t_vec3       o_c,
    output logic [SIDE_W-1:0]    o_side
);
    import ecb_pkg::*;

    localparam logic signed [63:0] HALF = 64'sd2147483648;

    logic [2:0]               r_v;
    logic signed [63:0]       r_p [0:5];
    logic signed [63:0]       r_d [0:2];
    logic [SIDE_W-1:0]        r_side [0:2];
    t_vec3                    r_c;

    logic signed [63:0]       n_r [0:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[1:0], i_valid};
        end
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_r[k] = r_d[k] + HALF;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // products
            r_p[0]    <= i_a.y * i_b.z;
            r_p[1]    <= i_a.z * i_b.y;
            r_p[2]    <= i_a.z * i_b.x;
            r_p[3]    <= i_a.x * i_b.z;
            r_p[4]    <= i_a.x * i_b.y;
            r_p[5]    <= i_a.y * i_b.x;
            r_side[0] <= i_side;
            // differences
            r_d[0]    <= r_p[0] - r_p[1];
            r_d[1]    <= r_p[2] - r_p[3];
            r_d[2]    <= r_p[4] - r_p[5];
            r_side[1] <= r_side[0];
            // round to nearest, ties up
            r_c.x     <= n_r[0][63:32];
            r_c.y     <= n_r[1][63:32];
            r_c.z     <= n_r[2][63:32];
            r_side[2] <= r_side[1];
        end
    end

    assign o_valid = r_v[2];
    assign o_c     = r_c;
    assign o_side  = r_side[2];

endmodule

`default_nettype wire

// ===== rtl/ecb_normalize.sv =====
// ============================================================================
// ecb_normalize
// pipelined normalisation: sum of squares, bit-serial square root and
// one-bit-per-stage rounded division, giving a q30 unit vector
// ============================================================================
`default_nettype none

module ecb_normalize #(
    parameter int SIDE_W = 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  ecb_pkg::t_vec3       i_v,
    input  logic [SIDE_W-1:0]    i_side,
    output logic                 o_valid,
    output ecb_pkg::t_vec3       o_u,
    output logic                 o_ok,
    output logic [SIDE_W-1:0]    o_side
);
    import ecb_pkg::*;

    localparam int SQ_STEPS  = 32;
    localparam int DIV_STEPS = 31;
    localparam int P_SQEND   = 3 + SQ_STEPS;
    localparam int LAST      = P_SQEND + 1 + DIV_STEPS;

    typedef struct packed {
        logic [2:0][31:0]  m;
        logic [2:0]        neg;
        logic [SIDE_W-1:0] side;
    } t_ctx;

    logic [LAST:0]      r_v;
    t_ctx               r_ctx [0:LAST];
    logic [2:0][63:0]   r_sq;
    logic [63:0]        r_p01;
    logic [63:0]        r_p2;
    logic [63:0]        r_n   [0:SQ_STEPS];
    logic [63:0]        r_r   [0:SQ_STEPS];
    logic [32:0]        r_s   [0:DIV_STEPS];
    logic [2:0][63:0]   r_rem [0:DIV_STEPS];
    logic [2:0][30:0]   r_qt  [0:DIV_STEPS];
    logic               r_ov;
    logic [2:0][31:0]   r_u;
    logic               r_ok;
    logic [SIDE_W-1:0]  r_side;

    logic [2:0][31:0]   n_v;
    t_ctx               n_ctx;
    logic               n_ok;

    always_comb begin
        n_v      = i_v;
        n_ctx.side = i_side;
        for (int c = 0; c < 3; c++) begin
            n_ctx.neg[c] = n_v[c][31];
            n_ctx.m[c]   = n_v[c][31] ? (32'd0 - n_v[c]) : n_v[c];
        end
        n_ok = (r_s[DIV_STEPS] != '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v  <= '0;
            r_ov <= 1'b0;
        end else if (i_en) begin
            r_v  <= {r_v[LAST-1:0], i_valid};
            r_ov <= r_v[LAST];
        end
    end

    always_ff @(posedge i_clk) begin
        logic [63:0] bitk;
        logic [63:0] trial;
        logic [63:0] dvs;
        if (i_en) begin
            r_ctx[0] <= n_ctx;
            for (int k = 0; k < LAST; k++) begin
                r_ctx[k+1] <= r_ctx[k];
            end
            // sum of squares
            for (int c = 0; c < 3; c++) begin
                r_sq[c] <= 64'(r_ctx[0].m[c]) * 64'(r_ctx[0].m[c]);
            end
            r_p01 <= r_sq[0] + r_sq[1];
            r_p2  <= r_sq[2];
            r_n[0] <= r_p01 + r_p2;
            r_r[0] <= '0;
            // floor square root, two radicand bits a stage
            for (int k = 0; k < SQ_STEPS; k++) begin
                bitk  = 64'd1 << (62 - 2 * k);
                trial = r_r[k] + bitk;
                if (r_n[k] >= trial) begin
                    r_n[k+1] <= r_n[k] - trial;
                    r_r[k+1] <= (r_r[k] >> 1) + bitk;
                end else begin
                    r_n[k+1] <= r_n[k];
                    r_r[k+1] <= r_r[k] >> 1;
                end
            end
            // rounded division (m * 2^30 + s/2) / s
            r_s[0] <= r_r[SQ_STEPS][32:0];
            for (int c = 0; c < 3; c++) begin
                r_rem[0][c] <= {2'b00, r_ctx[P_SQEND].m[c], 30'd0}
                             + 64'(r_r[SQ_STEPS][32:1]);
                r_qt[0][c]  <= '0;
            end
            for (int t = 0; t < DIV_STEPS; t++) begin
                r_s[t+1] <= r_s[t];
                dvs = 64'(r_s[t]) << (DIV_STEPS - 1 - t);
                for (int c = 0; c < 3; c++) begin
                    if (r_rem[t][c] >= dvs) begin
                        r_rem[t+1][c] <= r_rem[t][c] - dvs;
                        r_qt[t+1][c]  <= r_qt[t][c] | (31'd1 << (DIV_STEPS - 1 - t));
                    end else begin
                        r_rem[t+1][c] <= r_rem[t][c];
                        r_qt[t+1][c]  <= r_qt[t][c];
                    end
                end
            end
            // restore signs; zero vector gives zeros
            for (int c = 0; c < 3; c++) begin
                if (!n_ok) begin
                    r_u[c] <= '0;
                end else if (r_ctx[LAST].neg[c]) begin
                    r_u[c] <= 32'd0 - {1'b0, r_qt[DIV_STEPS][c]};
                end else begin
                    r_u[c] <= {1'b0, r_qt[DIV_STEPS][c]};
                end
            end
            r_ok   <= n_ok;
            r_side <= r_ctx[LAST].side;
        end
    end

    assign o_valid = r_ov;
    assign o_u     = r_u;
    assign o_ok    = r_ok;
    assign o_side  = r_side;

endmodule

`default_nettype wire

// ===== rtl/euler_camera_basis.sv =====
// ============================================================================
// euler_camera_basis
// orthonormal camera basis (forward, right, up) from a yaw and a pitch angle
// ============================================================================
// One transaction in, one transaction out, in order. The block is a single
// pipeline that takes a new angle pair every cycle unless stalled. It is
// made of the two 32-register cordic units, two forward registers, three
// normalisers of 69 registers each (a 32-stage square root and a 31-stage
// divider among them), two 3-stage cross products and the output register.
// A stalled output freezes the whole pipeline and the input stall follows it
// in the same cycle. World up is held pre-scaled to q30, so only its
// direction matters; write it only while the pipeline is empty. When the
// cross product of forward and world up is exactly zero the right and up
// fields are zero and the degenerate flag is set. There is no clearing pass.
`default_nettype none

module euler_camera_basis #(
    parameter int ANGLE_BITS = 16,
    parameter int FRAC_BITS  = 14
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    // input channel
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  ecb_pkg::t_in  i_in_data,
    // result channel
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output ecb_pkg::t_out o_out_data,
    // configuration channel
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic [1:0]    i_cfg_index,
    input  logic [15:0]   i_cfg_data
);
    import ecb_pkg::*;

    // world up register scale from output format to q30
    localparam int UP_SHIFT = 30 - FRAC_BITS;
    localparam logic signed [33:0] OUT_HALF = (34'sd1 <<< UP_SHIFT) >>> 1;
    localparam logic signed [33:0] OUT_LIM  = 34'sd1 <<< FRAC_BITS;
    localparam int CX_SIDE_W = 2 * VEC_W + 1;

    // q30 to output field: round half up, clamp, keep the low 16 bits
    function automatic logic signed [15:0] to_field(input t_q v);
        logic signed [33:0] r;
        r = (34'(v) + OUT_HALF) >>> UP_SHIFT;
        if (r > OUT_LIM) begin
            r = OUT_LIM;
        end
        if (r < -OUT_LIM) begin
            r = -OUT_LIM;
        end
        return r[15:0];
    endfunction

    // pipeline advances unless a finished result is held back
    logic adv;

    // world up, q30
    t_q r_wup_x;
    t_q r_wup_y;
    t_q r_wup_z;
    t_q n_wup;

    // cordic inputs and outputs
    logic [31:0] ya;
    logic [31:0] pa;
    logic        yaw_v;
    logic        pitch_v;
    t_cw         cos_y;
    t_cw         sin_y;
    t_cw         cos_p;
    t_cw         sin_p;
    t_q          cy;
    t_q          sy;
    t_q          cp;

    // raw forward vector stages
    logic               r_fa_v;
    logic signed [63:0] r_p_cc;
    logic signed [63:0] r_p_sc;
    t_cw                r_sp;
    logic               r_fb_v;
    t_vec3              r_raw;
    logic signed [63:0] n_cc;
    logic signed [63:0] n_sc;
    t_cw                n_sp;

    // basis stages
    logic                   fwd_v;
    t_vec3                  fwd;
    logic                   c1_v;
    t_vec3                  c1;
    logic [VEC_W-1:0]       c1_side;
    logic                   rgt_v;
    t_vec3                  rgt;
    logic                   rgt_ok;
    logic [VEC_W-1:0]       n2_side;
    logic                   c2_v;
    t_vec3                  c2;
    logic [CX_SIDE_W-1:0]   c2_side;
    logic                   up_v;
    t_vec3                  upv;
    logic [CX_SIDE_W-1:0]   n3_side;
    t_vec3                  f_fwd;
    t_vec3                  f_rgt;
    logic                   f_ok;

    // output register
    logic  r_out_valid;
    t_out  r_out_data;

    assign adv         = !(r_out_valid && i_out_stall);
    assign o_in_stall  = r_out_valid && i_out_stall;
    assign o_cfg_ready = 1'b1;

    // configuration writes, sign-extended and scaled to q30
    assign n_wup = t_q'($signed(i_cfg_data)) <<< UP_SHIFT;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wup_x <= '0;
            r_wup_y <= 32'sd1 <<< 30;
            r_wup_z <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_UP_X: r_wup_x <= n_wup;
                CFG_UP_Y: r_wup_y <= n_wup;
                CFG_UP_Z: r_wup_z <= n_wup;
                default:  ;
            endcase
        end
    end

    // binary angles into 2^32-per-turn units; bits above the angle width drop out
    assign ya = 32'(i_in_data.yaw_angle) << (32 - ANGLE_BITS);
    assign pa = 32'(i_in_data.pitch_angle) << (32 - ANGLE_BITS);

    ecb_sincos u_yaw (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_valid (i_in_valid),
        .i_angle (ya),
        .o_valid (yaw_v),
        .o_cos   (cos_y),
        .o_sin   (sin_y)
    );

    ecb_sincos u_pitch (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_valid (i_in_valid),
        .i_angle (pa),
        .o_valid (pitch_v),
        .o_cos   (cos_p),
        .o_sin   (sin_p)
    );

    // q30 magnitudes stay well inside 32 bits
    assign cy = t_q'(cos_y);
    assign sy = t_q'(sin_y);
    assign cp = t_q'(cos_p);

    // raw forward: cos yaw cos pitch, sin pitch, sin yaw cos pitch in q28
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fa_v <= 1'b0;
            r_fb_v <= 1'b0;
        end else if (adv) begin
            r_fa_v <= yaw_v && pitch_v;
            r_fb_v <= r_fa_v;
        end
    end

    always_comb begin
        n_cc = r_p_cc + 64'sd2147483648;
        n_sc = r_p_sc + 64'sd2147483648;
        n_sp = (r_sp + t_cw'(2)) >>> 2;
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_p_cc  <= cy * cp;
            r_p_sc  <= sy * cp;
            r_sp    <= sin_p;
            r_raw.x <= n_cc[63:32];
            r_raw.y <= t_q'(n_sp);
            r_raw.z <= n_sc[63:32];
        end
    end

    // unit forward
    ecb_normalize #(.SIDE_W(1)) u_norm_fwd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_valid (r_fb_v),
        .i_v     (r_raw),
        .i_side  (1'b0),
        .o_valid (fwd_v),
        .o_u     (fwd),
        .o_ok    (),
        .o_side  ()
    );

    // forward x world up
    ecb_cross #(.SIDE_W(VEC_W)) u_cross_rgt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_valid (fwd_v),
        .i_a     (fwd),
        .i_b     ({r_wup_x, r_wup_y, r_wup_z}),
        .i_side  (fwd),
        .o_valid (c1_v),
        .o_c     (c1),
        .o_side  (c1_side)
    );

    // unit right; a zero cross product marks the degenerate case
    ecb_normalize #(.SIDE_W(VEC_W)) u_norm_rgt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_valid (c1_v),
        .i_v     (c1),
        .i_side  (c1_side),
        .o_valid (rgt_v),
        .o_u     (rgt),
        .o_ok    (rgt_ok),
        .o_side  (n2_side)
    );

    // right x forward; a zero right gives a zero up
    ecb_cross #(.SIDE_W(CX_SIDE_W)) u_cross_up (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_valid (rgt_v),
        .i_a     (rgt),
        .i_b     (t_vec3'(n2_side)),
        .i_side  ({n2_side, rgt, rgt_ok}),
        .o_valid (c2_v),
        .o_c     (c2),
        .o_side  (c2_side)
    );

    ecb_normalize #(.SIDE_W(CX_SIDE_W)) u_norm_up (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_valid (c2_v),
        .i_v     (c2),
        .i_side  (c2_side),
        .o_valid (up_v),
        .o_u     (upv),
        .o_ok    (),
        .o_side  (n3_side)
    );

    assign f_fwd = t_vec3'(n3_side[CX_SIDE_W-1:VEC_W+1]);
    assign f_rgt = t_vec3'(n3_side[VEC_W:1]);
    assign f_ok  = n3_side[0];

    // output register, held while the result transaction is stalled
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= up_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_data.forward_x  <= to_field(f_fwd.x);
            r_out_data.forward_y  <= to_field(f_fwd.y);
            r_out_data.forward_z  <= to_field(f_fwd.z);
            r_out_data.right_x    <= to_field(f_rgt.x);
            r_out_data.right_y    <= to_field(f_rgt.y);
            r_out_data.right_z    <= to_field(f_rgt.z);
            r_out_data.up_x       <= to_field(upv.x);
            r_out_data.up_y       <= to_field(upv.y);
            r_out_data.up_z       <= to_field(upv.z);
            r_out_data.degenerate <= !f_ok;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

`ifndef NO_ASSERTIONS
    // a degenerate basis carries zero right and up vectors
    a_degenerate_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.degenerate |->
            o_out_data.right_x == 0 && o_out_data.right_y == 0 &&
            o_out_data.right_z == 0 && o_out_data.up_x == 0 &&
            o_out_data.up_y == 0 && o_out_data.up_z == 0)
        else $error("degenerate result with non-zero right or up");

    // the input is only held back by a waiting result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled without a held result");

    // reset empties the output register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid straight after reset");
`endif

endmodule

`default_nettype wire
